@@ src/gpio_register_block_unit_defines.svh @@
// Assertion macros shared by the GPIO register block RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef GPIO_REGISTER_BLOCK_UNIT_DEFINES_SVH
`define GPIO_REGISTER_BLOCK_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define GRB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// When the trigger holds, the check must hold at the next clock edge.
`define GRB_ASSERT_NEXT(lbl, trig, check, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (check)) \
        else $error(msg);

`endif

@@ src/grb_pkg.sv @@
// Register map, field codes and defaults for the GPIO register block.
// No dependencies.
`timescale 1ns / 1ps

package grb_pkg;

    localparam int DEFAULT_NUM_PINS = 32;
    localparam int DATA_W           = 32;
    localparam int OFFSET_W         = 10;
    localparam int FSEL_W           = 3;
    localparam int PULL_W           = 2;
    localparam int PINS_PER_FSEL    = 10;
    localparam int FSEL_WORDS       = 4;

    // Bus access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register word offsets.
    localparam logic [OFFSET_W-1:0] REG_SET      = 10'd7;
    localparam logic [OFFSET_W-1:0] REG_CLR      = 10'd10;
    localparam logic [OFFSET_W-1:0] REG_LEVEL    = 10'd13;
    localparam logic [OFFSET_W-1:0] REG_PULL     = 10'd37;
    localparam logic [OFFSET_W-1:0] REG_PULL_CLK = 10'd38;

    // Function select and pull codes.
    localparam logic [FSEL_W-1:0] FSEL_OUTPUT  = 3'h1;
    localparam logic [PULL_W-1:0] PULL_OFF     = 2'd0;
    localparam logic [PULL_W-1:0] PULL_DOWN    = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP      = 2'd2;
    localparam logic [PULL_W-1:0] PULL_OFF_ALT = 2'd3;

endpackage

@@ src/gpio_register_block_unit.sv @@
// GPIO register block top level: bus access decode, pin state and result register.
// Depends on grb_pkg and gpio_register_block_unit_defines.svh.
`timescale 1ns / 1ps
`include "gpio_register_block_unit_defines.svh"

// One bus access per beat. A beat is captured in an input register, decoded
// while the pin state is updated as it moves into the result register, and
// its result is held there. One beat per cycle is sustained while m_ready is
// high, set by the single decode stage between the two registers. The pin
// outputs on the result channel show the state after the access of the beat
// being presented. Reset puts every pin to input with pulls off and the
// output latch clear.
module gpio_register_block_unit
    import grb_pkg::*;
#(
    parameter int NUM_PINS = DEFAULT_NUM_PINS
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [OFFSET_W-1:0] s_word_offset,
    input  logic [DATA_W-1:0]   s_write_data,
    input  logic [DATA_W-1:0]   s_pad_levels,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [DATA_W-1:0]   m_read_data,
    output logic [DATA_W-1:0]   m_pin_drive,
    output logic [DATA_W-1:0]   m_pin_output_enable,
    output logic [DATA_W-1:0]   m_pull_up_enable,
    output logic [DATA_W-1:0]   m_pull_down_enable
);

    localparam int FSEL_SLOTS = FSEL_WORDS * PINS_PER_FSEL;
    localparam int FSEL_USED  = PINS_PER_FSEL * FSEL_W;
    localparam logic [DATA_W-1:0] PIN_MASK =
        DATA_W'((64'd1 << NUM_PINS) - 64'd1);

    // Input stage.
    logic                in_valid_reg;
    logic                op_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   pads_reg;

    // Result stage and shared state.
    logic                out_valid_reg;
    logic [DATA_W-1:0]   read_data_reg;
    logic [DATA_W-1:0]   read_data_next;
    logic [DATA_W-1:0]   latch_reg;
    logic [DATA_W-1:0]   latch_next;
    logic [PULL_W-1:0]   pull_ctrl_reg;
    logic [PULL_W-1:0]   pull_latch_mode;

    logic advance;
    logic wr_fire;

    logic [DATA_W-1:0]            oe_vec;
    logic [DATA_W-1:0]            up_vec;
    logic [DATA_W-1:0]            down_vec;
    logic [FSEL_SLOTS*FSEL_W-1:0] fsel_flat;
    logic [FSEL_USED-1:0]         fsel_word [FSEL_WORDS];

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign wr_fire = advance && (op_reg == OP_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_operation;
            offset_reg <= s_word_offset;
            data_reg   <= s_write_data;
            pads_reg   <= s_pad_levels;
        end
    end

    // Per-pin function select and latched pull mode.
    for (genvar p = 0; p < FSEL_SLOTS; p++) begin : g_pin
        if (p < NUM_PINS) begin : g_used
            localparam logic [OFFSET_W-1:0] WORD = OFFSET_W'(p / PINS_PER_FSEL);
            localparam int SLOT = p % PINS_PER_FSEL;

            logic [FSEL_W-1:0] fsel_reg;
            logic [PULL_W-1:0] pmode_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    fsel_reg  <= '0;
                    pmode_reg <= PULL_OFF;
                end else if (wr_fire) begin
                    if (offset_reg == WORD) begin
                        fsel_reg <= data_reg[SLOT*FSEL_W +: FSEL_W];
                    end
                    if ((offset_reg == REG_PULL_CLK) && data_reg[p]) begin
                        pmode_reg <= pull_latch_mode;
                    end
                end
            end

            assign fsel_flat[p*FSEL_W +: FSEL_W] = fsel_reg;
            assign oe_vec[p]   = (fsel_reg == FSEL_OUTPUT);
            assign up_vec[p]   = (pmode_reg == PULL_UP);
            assign down_vec[p] = (pmode_reg == PULL_DOWN);
        end else begin : g_absent
            assign fsel_flat[p*FSEL_W +: FSEL_W] = '0;
            if (p < DATA_W) begin : g_zero
                assign oe_vec[p]   = 1'b0;
                assign up_vec[p]   = 1'b0;
                assign down_vec[p] = 1'b0;
            end
        end
    end

    for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_fsel_word
        assign fsel_word[w] = fsel_flat[w*FSEL_USED +: FSEL_USED];
    end

    // Mode 3 latches as pull off.
    assign pull_latch_mode = (pull_ctrl_reg == PULL_OFF_ALT) ? PULL_OFF : pull_ctrl_reg;

    always_comb begin
        latch_next = latch_reg;
        if (wr_fire) begin
            if (offset_reg == REG_SET) begin
                latch_next = (latch_reg | data_reg) & PIN_MASK;
            end else if (offset_reg == REG_CLR) begin
                latch_next = latch_reg & ~data_reg & PIN_MASK;
            end
        end
    end

    always_comb begin
        read_data_next = '0;
        if (op_reg == OP_READ) begin
            if (offset_reg[OFFSET_W-1:2] == '0) begin
                read_data_next = DATA_W'(fsel_word[offset_reg[1:0]]);
            end else if (offset_reg == REG_LEVEL) begin
                read_data_next = ((latch_reg & oe_vec) | (pads_reg & ~oe_vec)) & PIN_MASK;
            end else if (offset_reg == REG_PULL) begin
                read_data_next = DATA_W'(pull_ctrl_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg     <= '0;
            pull_ctrl_reg <= PULL_OFF;
            out_valid_reg <= 1'b0;
        end else begin
            latch_reg <= latch_next;
            if (wr_fire && (offset_reg == REG_PULL)) begin
                pull_ctrl_reg <= data_reg[PULL_W-1:0];
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            read_data_reg <= read_data_next;
        end
    end

    // State only moves when a new beat enters the result register, so the
    // pin outputs can come straight from the state registers.
    assign m_valid             = out_valid_reg;
    assign m_read_data         = read_data_reg;
    assign m_pin_drive         = latch_reg;
    assign m_pin_output_enable = oe_vec;
    assign m_pull_up_enable    = up_vec;
    assign m_pull_down_enable  = down_vec;

    `GRB_ASSERT_NEXT(a_write_reads_zero, advance && (op_reg == OP_WRITE), m_read_data == '0, "write beat returned nonzero read data")
    `GRB_ASSERT_ALWAYS(a_pull_exclusive, (m_pull_up_enable & m_pull_down_enable) == '0, "pin has both pull up and pull down")
    `GRB_ASSERT_NEXT(a_state_held_stall, m_valid && !m_ready, $stable(m_pin_drive) && $stable(m_pin_output_enable) && $stable(m_pull_up_enable), "pin state moved while result stalled")
    `GRB_ASSERT_ALWAYS(a_ready_low_cause, s_ready || (in_valid_reg && m_valid && !m_ready), "input stalled without a full pipeline")

endmodule
